// ===== rtl/core/oledc_pkg.sv =====
// Shared constants for the monochrome display controller with command RAM:
// operation codes, command bytes, addressing modes, flag bits, argument counts.
// No dependencies.
package oledc_pkg;

    localparam int PANEL_COLUMNS = 128;
    localparam int PANEL_PAGES   = 8;
    localparam int COL_W         = $clog2(PANEL_COLUMNS);
    localparam int PAGE_W        = $clog2(PANEL_PAGES);
    localparam int ADDR_W        = COL_W + PAGE_W;
    localparam int RAM_DEPTH     = PANEL_COLUMNS * PANEL_PAGES;

    localparam logic [1:0] OP_COMMAND = 2'd0;
    localparam logic [1:0] OP_DATA    = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [1:0] MODE_HORIZONTAL = 2'd0;
    localparam logic [1:0] MODE_VERTICAL   = 2'd1;
    localparam logic [1:0] MODE_PAGE       = 2'd2;
    localparam logic [1:0] MODE_INVALID    = 2'd3;

    localparam int FLAG_REMAP   = 0;
    localparam int FLAG_SCANDEC = 1;
    localparam int FLAG_INVERT  = 2;
    localparam int FLAG_ALLON   = 3;
    localparam int FLAG_ON      = 4;

    localparam logic [7:0] CMD_COL_LOW      = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH     = 8'h10;
    localparam logic [7:0] CMD_SET_MODE     = 8'h20;
    localparam logic [7:0] CMD_COL_WINDOW   = 8'h21;
    localparam logic [7:0] CMD_PAGE_WINDOW  = 8'h22;
    localparam logic [7:0] CMD_HSCROLL_R    = 8'h26;
    localparam logic [7:0] CMD_HSCROLL_L    = 8'h27;
    localparam logic [7:0] CMD_VSCROLL_R    = 8'h29;
    localparam logic [7:0] CMD_VSCROLL_L    = 8'h2a;
    localparam logic [7:0] CMD_FIRST_LINE   = 8'h40;
    localparam logic [7:0] CMD_CONTRAST     = 8'h81;
    localparam logic [7:0] CMD_CHARGE_PUMP  = 8'h8d;
    localparam logic [7:0] CMD_REMAP_OFF    = 8'ha0;
    localparam logic [7:0] CMD_REMAP_ON     = 8'ha1;
    localparam logic [7:0] CMD_VSCROLL_AREA = 8'ha3;
    localparam logic [7:0] CMD_ALLON_OFF    = 8'ha4;
    localparam logic [7:0] CMD_ALLON_ON     = 8'ha5;
    localparam logic [7:0] CMD_NORMAL       = 8'ha6;
    localparam logic [7:0] CMD_INVERT       = 8'ha7;
    localparam logic [7:0] CMD_MULTIPLEX    = 8'ha8;
    localparam logic [7:0] CMD_DISPLAY_OFF  = 8'hae;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'haf;
    localparam logic [7:0] CMD_PAGE_ADDR    = 8'hb0;
    localparam logic [7:0] CMD_SCAN_INC     = 8'hc0;
    localparam logic [7:0] CMD_SCAN_DEC     = 8'hc8;
    localparam logic [7:0] CMD_OFFSET       = 8'hd3;
    localparam logic [7:0] CMD_CLOCK_DIV    = 8'hd5;
    localparam logic [7:0] CMD_PRECHARGE    = 8'hd9;
    localparam logic [7:0] CMD_COM_PINS     = 8'hda;
    localparam logic [7:0] CMD_VCOMH        = 8'hdb;

    localparam logic [3:0] PFX_COL_LOW    = 4'h0;
    localparam logic [3:0] PFX_COL_HIGH   = 4'h1;
    localparam logic [1:0] PFX_FIRST_LINE = 2'b01;
    localparam logic [4:0] PFX_PAGE_ADDR  = 5'b10110;

    localparam logic [6:0] MUX_MIN  = 7'd16;
    localparam logic [5:0] ROW_MASK = 6'd63;

    function automatic logic [2:0] needed_args(input logic [7:0] cmd);
        logic [2:0] n;
        n = 3'd0;
        case (cmd) inside
            CMD_SET_MODE, CMD_CONTRAST, CMD_CHARGE_PUMP, CMD_MULTIPLEX, CMD_OFFSET,
            CMD_CLOCK_DIV, CMD_PRECHARGE, CMD_COM_PINS, CMD_VCOMH: n = 3'd1;
            CMD_COL_WINDOW, CMD_PAGE_WINDOW, CMD_VSCROLL_AREA:     n = 3'd2;
            CMD_VSCROLL_R, CMD_VSCROLL_L:                          n = 3'd5;
            CMD_HSCROLL_R, CMD_HSCROLL_L:                          n = 3'd6;
            default:                                               n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/core/oled_controller_command_ram_top.sv =====
// Display controller top level: command decoder, pointer logic, page-organised
// display RAM and pixel read path with a registered result.
// Depends on oledc_pkg.
//
// Channel  | Dir | tdata bits (low first)                        | tuser
// s_axis   | in  | byte_value[7:0] pixel_x[14:8] pixel_y[20:15]  | operation[1:0]
// m_axis   | out | pixel_lit[0], zeros above                     | -
//
// Command and data items are taken straight from the idle state; a pixel read
// passes through the registered read port of the display RAM and then the result
// register. A read holds in ST_READ while the result register is full and not
// taken. After reset a clearing pass writes zero to all 1024 RAM bytes, one per
// cycle, and no item is accepted until the pass is done.
module oled_controller_command_ram_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // byte_value[7:0], pixel_x[14:8], pixel_y[20:15]
    input  logic [1:0]  i_s_axis_tuser,   // operation[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // pixel_lit[0]
);

    localparam int COL_W  = oledc_pkg::COL_W;
    localparam int PAGE_W = oledc_pkg::PAGE_W;
    localparam int ADDR_W = oledc_pkg::ADDR_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } t_state;

    t_state r_state, n_state;

    logic [7:0] r_ram [oledc_pkg::RAM_DEPTH];
    logic [7:0] r_rd_data;

    logic [ADDR_W-1:0] r_clr_addr;

    logic [COL_W:0]    r_col, n_col;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [1:0]        r_mode, n_mode;
    logic [COL_W-1:0]  r_cws, n_cws, r_cwe, n_cwe;
    logic [PAGE_W-1:0] r_pws, n_pws, r_pwe, n_pwe;
    logic [6:0]        r_mux, n_mux;
    logic [5:0]        r_offset, n_offset;
    logic [5:0]        r_first, n_first;
    logic [4:0]        r_flags, n_flags;
    logic [7:0]        r_wait_cmd, n_wait_cmd;
    logic [2:0]        r_args_left, n_args_left;
    logic [2:0]        r_args_seen, n_args_seen;
    logic [7:0]        r_arg1, n_arg1, r_arg2, n_arg2;

    logic       r_rd_force, r_rd_value, r_rd_inv;
    logic [2:0] r_rd_bit;
    logic       r_out_valid, r_out_lit;

    logic [1:0] in_op;
    logic [7:0] in_byte;
    logic [6:0] in_x;
    logic [5:0] in_y;
    logic       accept;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;

    logic [5:0]        com, row;
    logic [COL_W-1:0]  seg;
    logic [6:0]        mux_m1_y;
    logic [6:0]        mux_arg;
    logic              pix_force, pix_value;
    logic              out_free;

    assign in_op   = i_s_axis_tuser;
    assign in_byte = i_s_axis_tdata[7:0];
    assign in_x    = i_s_axis_tdata[14:8];
    assign in_y    = i_s_axis_tdata[20:15];

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_lit};

    // pixel address mapping
    always_comb begin
        mux_m1_y = r_mux - 7'd1 - {1'b0, in_y};
        com      = r_flags[oledc_pkg::FLAG_SCANDEC] ? mux_m1_y[5:0] : in_y;
        row      = (com + r_first + r_offset) & oledc_pkg::ROW_MASK;
        seg      = r_flags[oledc_pkg::FLAG_REMAP] ? ~in_x : in_x;
        pix_force = 1'b1;
        pix_value = 1'b0;
        if (!r_flags[oledc_pkg::FLAG_ON]) begin
            pix_value = 1'b0;
        end else if (r_flags[oledc_pkg::FLAG_ALLON]) begin
            pix_value = 1'b1;
        end else if ({1'b0, in_y} >= r_mux) begin
            pix_value = 1'b0;
        end else begin
            pix_force = 1'b0;
        end
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_page, r_col[COL_W-1:0]};
        mem_wdata = in_byte;
        mem_re    = 1'b0;
        mem_raddr = {row[5:3], seg};
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 8'd0;
        end else if (accept && in_op == oledc_pkg::OP_DATA && !r_col[COL_W]) begin
            mem_we = 1'b1;
        end
        if (accept && in_op == oledc_pkg::OP_READ) begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ram[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_ram[mem_raddr];
        end
    end

    // command, data and pointer next state
    always_comb begin
        n_col       = r_col;
        n_page      = r_page;
        n_mode      = r_mode;
        n_cws       = r_cws;
        n_cwe       = r_cwe;
        n_pws       = r_pws;
        n_pwe       = r_pwe;
        n_mux       = r_mux;
        n_offset    = r_offset;
        n_first     = r_first;
        n_flags     = r_flags;
        n_wait_cmd  = r_wait_cmd;
        n_args_left = r_args_left;
        n_args_seen = r_args_seen;
        n_arg1      = r_arg1;
        n_arg2      = r_arg2;
        mux_arg     = {1'b0, r_arg1[5:0]};

        if (accept && in_op == oledc_pkg::OP_COMMAND) begin
            if (r_args_left != 3'd0) begin
                if (r_args_seen == 3'd0) begin
                    n_arg1 = in_byte;
                end else if (r_args_seen == 3'd1) begin
                    n_arg2 = in_byte;
                end
                if (r_args_seen < 3'd7) begin
                    n_args_seen = r_args_seen + 3'd1;
                end
                n_args_left = r_args_left - 3'd1;
                mux_arg     = {1'b0, n_arg1[5:0]} + 7'd1;
                if (n_args_left == 3'd0) begin
                    case (r_wait_cmd)
                        oledc_pkg::CMD_SET_MODE: begin
                            if (n_arg1[1:0] != oledc_pkg::MODE_INVALID) begin
                                n_mode = n_arg1[1:0];
                            end
                        end
                        oledc_pkg::CMD_COL_WINDOW: begin
                            n_cws = n_arg1[COL_W-1:0];
                            n_cwe = n_arg2[COL_W-1:0];
                            n_col = {1'b0, n_arg1[COL_W-1:0]};
                        end
                        oledc_pkg::CMD_PAGE_WINDOW: begin
                            n_pws  = n_arg1[PAGE_W-1:0];
                            n_pwe  = n_arg2[PAGE_W-1:0];
                            n_page = n_arg1[PAGE_W-1:0];
                        end
                        oledc_pkg::CMD_MULTIPLEX: begin
                            if (mux_arg >= oledc_pkg::MUX_MIN) begin
                                n_mux = mux_arg;
                            end
                        end
                        oledc_pkg::CMD_OFFSET: begin
                            n_offset = n_arg1[5:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (oledc_pkg::needed_args(in_byte) != 3'd0) begin
                n_wait_cmd  = in_byte;
                n_args_left = oledc_pkg::needed_args(in_byte);
                n_args_seen = 3'd0;
            end else if (in_byte[7:4] == oledc_pkg::PFX_COL_LOW) begin
                n_col = {r_col[7:4], in_byte[3:0]};
            end else if (in_byte[7:4] == oledc_pkg::PFX_COL_HIGH) begin
                n_col = {in_byte[3:0], r_col[3:0]};
            end else if (in_byte[7:6] == oledc_pkg::PFX_FIRST_LINE) begin
                n_first = in_byte[5:0];
            end else if (in_byte[7:3] == oledc_pkg::PFX_PAGE_ADDR) begin
                n_page = in_byte[PAGE_W-1:0];
            end else begin
                case (in_byte)
                    oledc_pkg::CMD_REMAP_OFF:   n_flags[oledc_pkg::FLAG_REMAP]   = 1'b0;
                    oledc_pkg::CMD_REMAP_ON:    n_flags[oledc_pkg::FLAG_REMAP]   = 1'b1;
                    oledc_pkg::CMD_ALLON_OFF:   n_flags[oledc_pkg::FLAG_ALLON]   = 1'b0;
                    oledc_pkg::CMD_ALLON_ON:    n_flags[oledc_pkg::FLAG_ALLON]   = 1'b1;
                    oledc_pkg::CMD_NORMAL:      n_flags[oledc_pkg::FLAG_INVERT]  = 1'b0;
                    oledc_pkg::CMD_INVERT:      n_flags[oledc_pkg::FLAG_INVERT]  = 1'b1;
                    oledc_pkg::CMD_DISPLAY_OFF: n_flags[oledc_pkg::FLAG_ON]      = 1'b0;
                    oledc_pkg::CMD_DISPLAY_ON:  n_flags[oledc_pkg::FLAG_ON]      = 1'b1;
                    oledc_pkg::CMD_SCAN_INC:    n_flags[oledc_pkg::FLAG_SCANDEC] = 1'b0;
                    oledc_pkg::CMD_SCAN_DEC:    n_flags[oledc_pkg::FLAG_SCANDEC] = 1'b1;
                    default: begin
                    end
                endcase
            end
        end else if (accept && in_op == oledc_pkg::OP_DATA) begin
            case (r_mode)
                oledc_pkg::MODE_HORIZONTAL: begin
                    if (r_col >= {1'b0, r_cwe}) begin
                        n_col  = {1'b0, r_cws};
                        n_page = (r_page >= r_pwe) ? r_pws : r_page + 3'd1;
                    end else begin
                        n_col = r_col + 8'd1;
                    end
                end
                oledc_pkg::MODE_VERTICAL: begin
                    if (r_page >= r_pwe) begin
                        n_page = r_pws;
                        n_col  = (r_col >= {1'b0, r_cwe}) ? {1'b0, r_cws} : r_col + 8'd1;
                    end else begin
                        n_page = r_page + 3'd1;
                    end
                end
                default: begin
                    n_col = {1'b0, r_col[COL_W-1:0] + 7'd1};
                end
            endcase
        end
    end

    // sequencing and result register
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(oledc_pkg::RAM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && in_op == oledc_pkg::OP_READ) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_page      <= '0;
            r_mode      <= oledc_pkg::MODE_PAGE;
            r_cws       <= '0;
            r_cwe       <= COL_W'(oledc_pkg::PANEL_COLUMNS - 1);
            r_pws       <= '0;
            r_pwe       <= PAGE_W'(oledc_pkg::PANEL_PAGES - 1);
            r_mux       <= 7'd64;
            r_offset    <= '0;
            r_first     <= '0;
            r_flags     <= '0;
            r_wait_cmd  <= '0;
            r_args_left <= '0;
            r_args_seen <= '0;
            r_arg1      <= '0;
            r_arg2      <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= r_clr_addr + ADDR_W'(1);
            r_col       <= n_col;
            r_page      <= n_page;
            r_mode      <= n_mode;
            r_cws       <= n_cws;
            r_cwe       <= n_cwe;
            r_pws       <= n_pws;
            r_pwe       <= n_pwe;
            r_mux       <= n_mux;
            r_offset    <= n_offset;
            r_first     <= n_first;
            r_flags     <= n_flags;
            r_wait_cmd  <= n_wait_cmd;
            r_args_left <= n_args_left;
            r_args_seen <= n_args_seen;
            r_arg1      <= n_arg1;
            r_arg2      <= n_arg2;
            if (r_state == ST_READ && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (mem_re) begin
            r_rd_force <= pix_force;
            r_rd_value <= pix_value;
            r_rd_inv   <= r_flags[oledc_pkg::FLAG_INVERT];
            r_rd_bit   <= row[2:0];
        end
        if (r_state == ST_READ && out_free) begin
            r_out_lit <= r_rd_force ? r_rd_value : (r_rd_data[r_rd_bit] ^ r_rd_inv);
        end
    end

endmodule
